// ===== rtl/dptc_pkg.sv =====
// Package for the dispense pump tick controller: payload structs, register
// indexes, field widths and reset values. No dependencies.
`default_nettype none

package dptc_pkg;

   // Field widths
   localparam int DeltaWidth  = 16;
   localparam int AccumWidth  = 32;
   localparam int TargetWidth = 16;
   localparam int ThrWidth    = 8;
   localparam int TickWidth   = 10;
   localparam int OnWidth     = 8;
   localparam int LevelWidth  = 10;
   localparam int BlinkWidth  = 7;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 16;

   // Blink counter thresholds
   localparam logic [BlinkWidth-1:0] BlinkHalf = 7'd50;
   localparam logic [BlinkWidth-1:0] BlinkFull = 7'd100;

   // Register reset values
   localparam logic [TargetWidth-1:0] TargetReset  = 16'd0;
   localparam logic [ThrWidth-1:0]    ThrReset     = 8'd8;
   localparam logic [TickWidth-1:0]   HoldReset    = 10'd150;
   localparam logic [OnWidth-1:0]     OnReset      = 8'd15;
   localparam logic [TickWidth-1:0]   CycleReset   = 10'd220;
   localparam logic [LevelWidth-1:0]  PumpSpdReset = 10'd190;
   localparam logic [LevelWidth-1:0]  ManSpdReset  = 10'd500;

   // Register indexes on the csr port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TARGET_DISTANCE = 3'd0,
      CSR_SPEED_THRESHOLD = 3'd1,
      CSR_HOLD_TICKS      = 3'd2,
      CSR_PUMP_ON_TICKS   = 3'd3,
      CSR_PUMP_CYCLE      = 3'd4,
      CSR_PUMP_SPEED      = 3'd5,
      CSR_MANUAL_SPEED    = 3'd6
   } csr_index_type;

   // One tick item
   typedef struct packed {
      logic signed [DeltaWidth-1:0] encoder_delta;
      logic                         armed;
      logic                         run_pressed;
      logic                         manual_pressed;
   } dptc_req_type;

   // One tick result
   typedef struct packed {
      logic                         finish;
      logic [LevelWidth-1:0]        motor_level;
      logic                         run_led_n;
      logic                         pump_led_n;
      logic                         manual_led_n;
      logic signed [AccumWidth-1:0] distance_counts;
   } dptc_rsp_type;

endpackage : dptc_pkg

`default_nettype wire

// ===== rtl/dispense_pump_tick_controller_core.sv =====
// Dispense pump tick controller top level: input register, tick logic and
// result register. Depends on dptc_pkg.
`default_nettype none

// Usage
//   req_*  : one transaction per 10 ms tick (encoder delta, armed, buttons).
//   rsp_*  : one result transaction per tick (finish, motor level, LED pins,
//            accumulated distance), in order.
//   csr_*  : register writes, always ready; write only while the block idles.
// Path: a taken tick is held in the input register, then the tick logic
//   settles its result into the result register.
// Throughput: one tick per cycle while results are taken. The result register frees the input
//   register, so a new tick is taken while one result waits on rsp_stall;
//   req_stall rises only when both registers are full and rsp_stall is high.
// Reset: clears distance, counters and motor level, turns all LEDs off and
//   loads the default register values; no results are pending.
// A stalled result holds its payload until taken.
module dispense_pump_tick_controller_core (
   input  wire                           clock,
   input  wire                           reset,
   // tick input
   input  wire                           req_valid,
   output logic                          req_stall,
   input  dptc_pkg::dptc_req_type        req_data,
   // result output
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output dptc_pkg::dptc_rsp_type        rsp_data,
   // register writes
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [dptc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire [dptc_pkg::CsrDatWidth-1:0] csr_data
);
   import dptc_pkg::*;

   // Configuration registers
   logic [TargetWidth-1:0] target_ff;
   logic [ThrWidth-1:0]    thr_ff;
   logic [TickWidth-1:0]   hold_ff;
   logic [OnWidth-1:0]     on_ff;
   logic [TickWidth-1:0]   cycle_ff;
   logic [LevelWidth-1:0]  pump_spd_ff;
   logic [LevelWidth-1:0]  man_spd_ff;

   // Pipeline registers
   logic         in_valid_ff;
   dptc_req_type in_data_ff;
   logic         rsp_valid_ff;
   dptc_rsp_type rsp_data_ff;
   logic         advance;

   // Tick state
   logic signed [AccumWidth-1:0] accum_ff, accum_in;
   logic [TickWidth-1:0]         fast_ff, fast_in;
   logic [TickWidth-1:0]         phase_ff, phase_in;
   logic [BlinkWidth-1:0]        blink_ff, blink_in;
   logic [LevelWidth-1:0]        motor_ff, motor_in;
   logic [2:0]                   pins_ff, pins_in;   // bit0 run, bit1 pump, bit2 manual
   logic                         finish_in;

   // Datapath intermediates
   logic signed [AccumWidth:0]   sum_full;
   logic signed [AccumWidth-1:0] sum_sat;
   logic signed [AccumWidth+1:0] sum_x3;
   logic [22:0]                  target_x80;
   logic [DeltaWidth:0]          delta_ext;
   logic [DeltaWidth:0]          mag;
   logic                         is_fast;
   logic [TickWidth:0]           tick_inc;
   logic [TickWidth:0]           phase_inc;
   logic [BlinkWidth:0]          blink_inc;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TargetReset;
         thr_ff      <= ThrReset;
         hold_ff     <= HoldReset;
         on_ff       <= OnReset;
         cycle_ff    <= CycleReset;
         pump_spd_ff <= PumpSpdReset;
         man_spd_ff  <= ManSpdReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_DISTANCE: target_ff   <= csr_data;
            CSR_SPEED_THRESHOLD: thr_ff      <= csr_data[ThrWidth-1:0];
            CSR_HOLD_TICKS:      hold_ff     <= csr_data[TickWidth-1:0];
            CSR_PUMP_ON_TICKS:   on_ff       <= csr_data[OnWidth-1:0];
            CSR_PUMP_CYCLE:      cycle_ff    <= csr_data[TickWidth-1:0];
            CSR_PUMP_SPEED:      pump_spd_ff <= csr_data[LevelWidth-1:0];
            CSR_MANUAL_SPEED:    man_spd_ff  <= csr_data[LevelWidth-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the held tick moves on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Tick logic
   always_comb begin
      // saturating distance sum
      sum_full = $signed({accum_ff[AccumWidth-1], accum_ff})
               + $signed({{(AccumWidth-DeltaWidth+1){in_data_ff.encoder_delta[DeltaWidth-1]}},
                          in_data_ff.encoder_delta});
      if (sum_full[AccumWidth] != sum_full[AccumWidth-1]) begin
         sum_sat = sum_full[AccumWidth] ? {1'b1, {(AccumWidth-1){1'b0}}}
                                        : {1'b0, {(AccumWidth-1){1'b1}}};
      end else begin
         sum_sat = sum_full[AccumWidth-1:0];
      end

      // finish: sum*3 >= target*80
      sum_x3     = $signed({{2{sum_sat[AccumWidth-1]}}, sum_sat})
                 + $signed({sum_sat[AccumWidth-1], sum_sat, 1'b0});
      target_x80 = {1'b0, target_ff, 6'b0} + {3'b0, target_ff, 4'b0};
      finish_in  = sum_x3 >= $signed({11'b0, target_x80});

      // speed test on |delta|
      delta_ext = {in_data_ff.encoder_delta[DeltaWidth-1], in_data_ff.encoder_delta};
      mag       = delta_ext[DeltaWidth] ? (~delta_ext + 17'd1) : delta_ext;
      is_fast   = mag > {9'b0, thr_ff};

      tick_inc  = {1'b0, fast_ff} + 11'd1;
      phase_inc = {1'b0, phase_ff} + 11'd1;
      blink_inc = {1'b0, blink_ff} + 8'd1;

      accum_in = sum_sat;
      fast_in  = fast_ff;
      phase_in = phase_ff;
      blink_in = blink_ff;
      motor_in = motor_ff;
      pins_in  = pins_ff;

      if (in_data_ff.armed) begin
         if (in_data_ff.run_pressed) begin
            pins_in[0] = 1'b0;
            if (is_fast) begin
               if (tick_inc >= {1'b0, hold_ff}) begin
                  // hold time reached: pump cycle
                  fast_in    = hold_ff;
                  pins_in[1] = 1'b0;
                  if (phase_inc < {3'b0, on_ff}) begin
                     motor_in = pump_spd_ff;
                  end else if (phase_inc > {3'b0, on_ff}) begin
                     motor_in = '0;
                  end
                  if (phase_inc > {1'b0, cycle_ff}) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_inc[TickWidth-1:0];
                  end
               end else begin
                  fast_in = tick_inc[TickWidth-1:0];
               end
            end else begin
               fast_in    = '0;
               phase_in   = '0;
               pins_in[1] = 1'b1;
               motor_in   = '0;
            end
         end else begin
            // released: clear and allow manual pumping
            fast_in    = '0;
            phase_in   = '0;
            accum_in   = '0;
            pins_in[0] = 1'b1;
            pins_in[1] = 1'b1;
            pins_in[2] = !in_data_ff.manual_pressed;
            motor_in   = in_data_ff.manual_pressed ? man_spd_ff : '0;
         end
      end else begin
         // blink mode
         pins_in[1] = 1'b1;
         blink_in   = blink_inc[BlinkWidth-1:0];
         if (blink_inc < {1'b0, BlinkHalf}) begin
            pins_in[0] = 1'b0;
         end else if (blink_inc > {1'b0, BlinkHalf} && blink_inc < {1'b0, BlinkFull}) begin
            pins_in[0] = 1'b1;
         end else if (blink_inc > {1'b0, BlinkFull}) begin
            blink_in = '0;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         accum_ff     <= '0;
         fast_ff      <= '0;
         phase_ff     <= '0;
         blink_ff     <= '0;
         motor_ff     <= '0;
         pins_ff      <= 3'b111;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            accum_ff     <= accum_in;
            fast_ff      <= fast_in;
            phase_ff     <= phase_in;
            blink_ff     <= blink_in;
            motor_ff     <= motor_in;
            pins_ff      <= pins_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff.finish          <= finish_in;
         rsp_data_ff.motor_level     <= motor_in;
         rsp_data_ff.run_led_n       <= pins_in[0];
         rsp_data_ff.pump_led_n      <= pins_in[1];
         rsp_data_ff.manual_led_n    <= pins_in[2];
         rsp_data_ff.distance_counts <= accum_in;
      end
   end

`ifndef SYNTHESIS
   // Pump LED lit only together with the run LED
   a_pump_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pump_led_n |-> !rsp_data.run_led_n)
      else $error("pump LED lit without run LED");

   // Releasing run clears the reported distance
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.armed && !in_data_ff.run_pressed
      |=> rsp_data.distance_counts == 0)
      else $error("distance not cleared on release");

   // Both stages full under stall must push back on the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while pipeline is full");
`endif

endmodule : dispense_pump_tick_controller_core

`default_nettype wire
